FILE: rtl/core/pidl_pkg.sv
// types and constants shared by the positional insert/delete list
`timescale 1ns / 1ps
`default_nettype none

package pidl_pkg;

  // list capacity, fixed by the widths of the count and position fields
  localparam int unsigned Depth   = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned CountW  = 5;
  localparam int unsigned PosW    = 4;

  typedef enum logic [2:0] {
    OP_PUSH_BACK    = 3'd0,
    OP_PUSH_FRONT   = 3'd1,
    OP_INSERT       = 3'd2,
    OP_REMOVE_AT    = 3'd3,
    OP_POP_BACK     = 3'd4,
    OP_POP_FRONT    = 3'd5,
    OP_REMOVE_RANGE = 3'd6,
    OP_SHOW         = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  // the operation that every cell of the chain carries out
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e               op;
    logic [DataW-1:0]       value;
  } cell_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/pidl_cell.sv
// one storage cell of the list chain
`timescale 1ns / 1ps
`default_nettype none

module pidl_cell import pidl_pkg::*; #(
  parameter int unsigned IDX = 0,
  parameter int unsigned PW  = 4,
  parameter int unsigned CW  = 5
) (
  input  wire logic             clk_i,
  input  wire cell_cmd_t        cmd_i,
  input  wire logic [PW-1:0]    pos_i,
  input  wire logic [CW-1:0]    count_i,
  input  wire logic [DataW-1:0] left_i,
  input  wire logic [DataW-1:0] right_i,
  input  wire logic [DataW-1:0] head_i,
  output logic      [DataW-1:0] data_o
);

  localparam logic [PW-1:0] MyPos = PW'(IDX);
  localparam logic [CW-1:0] MyCnt = CW'(IDX);

  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        // open a gap at pos, everything above moves up one
        if (MyPos == pos_i) begin
          data_d = cmd_i.value;
        end else if (MyPos > pos_i && MyCnt <= count_i) begin
          data_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (MyPos >= pos_i) begin
          data_d = right_i;
        end
      end
      CELL_ROTATE: begin
        // rotate the used part left, head wraps to the top
        if (MyCnt + 1'b1 == count_i) begin
          data_d = head_i;
        end else if (MyCnt < count_i) begin
          data_d = right_i;
        end
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: rtl/core/positional_insert_delete_list.sv
// top level of the positional insert/delete list
//
// ordered list of up to Depth (16) signed 32-bit entries kept in a chain of cells
// usage:
//   - a command word (op_i, value_i, index_i, right_index_i) is taken on a
//     rising edge with start_i high and busy_o low
//   - each result word is on the result ports for one cycle with valid_o high;
//     the receiver cannot stall, so nothing is held back
// timing:
//   - push, insert, single remove and pop: busy_o stays low, the result word
//     shows up the cycle after the command
//   - remove range: one entry removed per cycle, the cells from the range's left
//     end upward shifting left; busy_o high until the last entry goes
//   - show: the chain rotates left once per cycle and cell 0 feeds the result
//     port; after the last entry the order is back as it was
//   - error or show of an empty list: one result word
// reset: entry count and control clear at once, cell contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_delete_list import pidl_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [2:0]               op_i,
  input  wire logic signed [DataW-1:0]  value_i,
  input  wire logic [IdxW-1:0]          index_i,
  input  wire logic [IdxW-1:0]          right_index_i,
  output logic                          valid_o,
  output logic [1:0]                    status_o,
  output logic [CountW-1:0]             count_o,
  output logic                          has_element_o,
  output logic signed [DataW-1:0]       element_o,
  output logic [PosW-1:0]               element_position_o,
  output logic                          last_o
);

  // count holds 0..Depth, cell positions 0..Depth-1
  localparam int unsigned CW   = $clog2(Depth + 1);
  localparam int unsigned PW   = $clog2(Depth);
  localparam int unsigned CMPW = (CW > IdxW) ? CW : IdxW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_SHOW
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IdxW-1:0]   rem_q, rem_d;     // deletions still to do in a range
  logic [PW-1:0]     lo_q, lo_d;       // left end of the range being removed
  logic [PW-1:0]     pos_q, pos_d;     // show position

  // registered result word
  logic              valid_q, res_valid;
  status_e           status_q, res_status;
  logic [CountW-1:0] rcount_q;
  logic              has_q, res_has;
  logic [DataW-1:0]  elem_q, res_elem;
  logic [PosW-1:0]   epos_q, res_pos;
  logic              last_q, res_last;

  cell_cmd_t         cmd;
  logic [PW-1:0]     cmd_pos;
  logic [DataW-1:0]  cell_q [Depth];

  logic              accept;
  logic              full, empty;
  logic [CMPW-1:0]   idx_w, ridx_w, cnt_w;
  logic              show_last;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign full   = (count_q == CW'(Depth));
  assign empty  = (count_q == '0);
  assign idx_w  = CMPW'(index_i);
  assign ridx_w = CMPW'(right_index_i);
  assign cnt_w  = CMPW'(count_q);
  assign show_last = (CW'(pos_q) + 1'b1 == count_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rem_d      = rem_q;
    lo_d       = lo_q;
    pos_d      = pos_q;
    cmd.op     = CELL_HOLD;
    cmd.value  = value_i;
    cmd_pos    = '0;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_has    = 1'b0;
    res_elem   = '0;
    res_pos    = '0;
    res_last   = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid = 1'b1;
          case (op_e'(op_i))
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
              if (full) begin
                res_status = ST_FULL;
              end else if (op_e'(op_i) == OP_INSERT && idx_w > cnt_w) begin
                res_status = ST_BAD;
              end else begin
                cmd.op  = CELL_INSERT;
                count_d = count_q + 1'b1;
                if (op_e'(op_i) == OP_PUSH_BACK) begin
                  cmd_pos = PW'(count_q);
                end else if (op_e'(op_i) == OP_INSERT) begin
                  cmd_pos = PW'(index_i);
                end
              end
            end
            OP_REMOVE_AT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (idx_w >= cnt_w) begin
                res_status = ST_BAD;
              end else begin
                cmd.op  = CELL_DELETE;
                cmd_pos = PW'(index_i);
                count_d = count_q - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                cmd.op  = CELL_DELETE;
                cmd_pos = PW'(count_q - 1'b1);
                count_d = count_q - 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                cmd.op  = CELL_DELETE;
                count_d = count_q - 1'b1;
              end
            end
            OP_REMOVE_RANGE: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else if (idx_w > ridx_w || ridx_w >= cnt_w) begin
                res_status = ST_BAD;
              end else begin
                // first entry goes now, the rest one per cycle
                cmd.op  = CELL_DELETE;
                cmd_pos = PW'(index_i);
                count_d = count_q - 1'b1;
                if (right_index_i != index_i) begin
                  res_valid = 1'b0;
                  state_d   = S_REMOVE;
                  rem_d     = right_index_i - index_i;
                  lo_d      = PW'(index_i);
                end
              end
            end
            OP_SHOW: begin
              if (!empty) begin
                res_valid = 1'b0;
                state_d   = S_SHOW;
                pos_d     = '0;
              end
            end
            default: begin
              res_status = ST_OK;
            end
          endcase
        end
      end
      S_REMOVE: begin
        cmd.op  = CELL_DELETE;
        cmd_pos = lo_q;
        count_d = count_q - 1'b1;
        rem_d   = rem_q - 1'b1;
        if (rem_q == IdxW'(1)) begin
          res_valid = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_SHOW: begin
        // cell 0 always holds the next entry while the chain rotates
        cmd.op    = CELL_ROTATE;
        res_valid = 1'b1;
        res_has   = 1'b1;
        res_elem  = cell_q[0];
        res_pos   = PosW'(pos_q);
        res_last  = show_last;
        pos_d     = pos_q + 1'b1;
        if (show_last) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rem_q    <= '0;
      lo_q     <= '0;
      pos_q    <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_OK;
      rcount_q <= '0;
      has_q    <= 1'b0;
      elem_q   <= '0;
      epos_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
      lo_q     <= lo_d;
      pos_q    <= pos_d;
      valid_q  <= res_valid;
      status_q <= res_status;
      rcount_q <= CountW'(count_d);
      has_q    <= res_has;
      elem_q   <= res_elem;
      epos_q   <= res_pos;
      last_q   <= res_last;
    end
  end

  // the chain: each cell sees its neighbors and the head
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataW-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end

    pidl_cell #(
      .IDX (i),
      .PW  (PW),
      .CW  (CW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (cmd_pos),
      .count_i (count_q),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (cell_q[0]),
      .data_o  (cell_q[i])
    );
  end

  assign valid_o            = valid_q;
  assign status_o           = status_q;
  assign count_o            = rcount_q;
  assign has_element_o      = has_q;
  assign element_o          = elem_q;
  assign element_position_o = epos_q;
  assign last_o             = last_q;

  // show words come out back to back until the last one
  a_show_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("show burst broken");

  // every accepted command gives a word next cycle or keeps the block busy
  a_cmd_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> valid_o || busy_o)
    else $error("command lost");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("entry count above depth");

  // a range removal drops exactly one entry per cycle
  a_remove_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_REMOVE |=> count_q + 1'b1 == $past(count_q))
    else $error("range removal step wrong");

  a_shown_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && has_element_o |-> status_o == ST_OK)
    else $error("shown entry with error status");

endmodule

`default_nettype wire
